// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define WGB_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WGB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wgb_pkg.sv =====
`default_nettype none

package wgb_pkg;

    localparam int OP_W       = 3;
    localparam int DATA_W     = 64;
    localparam int PTR_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_BYTE  = 3'd0;
    localparam logic [OP_W-1:0] OP_HALF  = 3'd1;
    localparam logic [OP_W-1:0] OP_WORD  = 3'd2;
    localparam logic [OP_W-1:0] OP_DWORD = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_END  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PTR = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // store side to sequencer
    typedef struct packed {
        logic       grow_en;
        logic [3:0] grow;
        logic       flush_req;
    } pack_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wgb_if.sv =====
`default_nettype none

interface wgb_store_if
    import wgb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    logic              check;

    modport source (output valid, op, value, check, input ready);
    modport sink (input valid, op, value, check, output ready);
endinterface

interface wgb_burst_if
    import wgb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PTR_W-1:0]  mem_addr;
    logic [DATA_W-1:0] mem_data;
    logic              burst_last;
    logic              run_last;
    logic              overrun;

    modport source (output valid, mem_addr, mem_data, burst_last, run_last, overrun,
                    input ready);
    modport sink (input valid, mem_addr, mem_data, burst_last, run_last, overrun,
                  output ready);
endinterface

interface wgb_cfg_if
    import wgb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wgb_ram.sv =====
`default_nettype none

module wgb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wgb_pack.sv =====
`default_nettype none

module wgb_pack
    import wgb_pkg::*;
#(
    parameter int BUFFER_BYTES = 512,
    localparam int WORDS  = BUFFER_BYTES / 8,
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1,
    localparam int FILL_W = $clog2(BUFFER_BYTES + 1)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [OP_W-1:0]   op,
    input  logic [DATA_W-1:0] value,
    input  logic              check,
    input  logic [FILL_W-1:0] fill,
    input  logic [ADDR_W-1:0] head,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [DATA_W-1:0] wr_data,
    output pack_stat_t        stat
);

    localparam int SUM_W = FILL_W - 2;

    // partial tail word, bytes packed from the top, unused bytes kept zero
    logic [DATA_W-1:0]   tail_reg;
    logic [DATA_W-1:0]   tail_next;
    logic [3:0]          size;
    logic [DATA_W-1:0]   data_al;
    logic                is_store;
    logic [2:0]          tail_cnt;
    logic [2*DATA_W-1:0] merged;
    logic                spill;
    logic                fits;
    logic [FILL_W:0]     fill_sum;
    logic [SUM_W-1:0]    idx_sum;

    always_comb
    begin
        is_store = op < OP_FLUSH;
        size     = 4'd0;
        data_al  = '0;
        case (op)
            OP_BYTE:
            begin
                size    = 4'd1;
                data_al = {value[7:0], 56'd0};
            end
            OP_HALF:
            begin
                size    = 4'd2;
                data_al = {value[15:0], 48'd0};
            end
            OP_WORD:
            begin
                size    = 4'd4;
                data_al = {value[31:0], 32'd0};
            end
            OP_DWORD:
            begin
                size    = 4'd8;
                data_al = value;
            end
            default:
            begin
                size    = 4'd0;
                data_al = '0;
            end
        endcase

        tail_cnt = fill[2:0];
        merged   = {tail_reg, {DATA_W{1'b0}}}
                 | ({data_al, {DATA_W{1'b0}}} >> {tail_cnt, 3'b000});
        fill_sum = {1'b0, fill} + (FILL_W + 1)'(size);
        fits     = fill_sum <= (FILL_W + 1)'(BUFFER_BYTES);
        spill    = ({1'b0, tail_cnt} + size) >= 4'd8;

        // word slot just past the last full word, on the ring
        idx_sum = SUM_W'(head) + SUM_W'(fill[FILL_W-1:3]);
        if (idx_sum >= SUM_W'(WORDS))
        begin
            idx_sum = idx_sum - SUM_W'(WORDS);
        end

        wr_en   = accept && is_store && fits && spill;
        wr_addr = idx_sum[ADDR_W-1:0];
        wr_data = merged[2*DATA_W-1:DATA_W];

        tail_next = tail_reg;
        if (accept && is_store && fits)
        begin
            tail_next = spill ? merged[DATA_W-1:0] : merged[2*DATA_W-1:DATA_W];
        end

        stat.grow_en   = is_store && fits;
        stat.grow      = size;
        stat.flush_req = check || !is_store;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg <= '0;
        end
        else
        begin
            tail_reg <= tail_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wgb_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module wgb_ctrl
    import wgb_pkg::*;
#(
    parameter int BURST_BYTES  = 32,
    parameter int BUFFER_BYTES = 512,
    localparam int WORDS  = BUFFER_BYTES / 8,
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1,
    localparam int FILL_W = $clog2(BUFFER_BYTES + 1)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  pack_stat_t        stat,
    output logic              in_ready,
    output logic [FILL_W-1:0] fill,
    output logic [ADDR_W-1:0] head,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [DATA_W-1:0] rd_data,
    wgb_burst_if.source       burst,
    wgb_cfg_if.sink           cfg
);

    localparam int WPB    = BURST_BYTES / 8;
    localparam int WCNT_W = (WPB > 1) ? $clog2(WPB) : 1;
    localparam int SUM_W  = FILL_W - 2;

    state_t            state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [WCNT_W-1:0] wcnt_reg, wcnt_next;
    logic [PTR_W-1:0]  ring_base_reg, ring_base_next;
    logic [PTR_W-1:0]  ring_end_reg, ring_end_next;
    logic              hold_reg, hold_next;
    logic              out_valid_reg, out_valid_next;

    // word in flight through the ram read register
    logic [PTR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic              pend_blast_reg, pend_blast_next;
    logic              pend_rlast_reg, pend_rlast_next;
    logic              pend_over_reg, pend_over_next;

    logic [PTR_W-1:0]  out_addr_reg, out_addr_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_blast_reg, out_blast_next;
    logic              out_rlast_reg, out_rlast_next;
    logic              out_over_reg, out_over_next;

    logic [PTR_W-1:0]  next_ptr;
    logic              over;
    logic              wrap;
    logic              move;
    logic              issue;
    logic              last_word;
    logic              small_rest;
    logic [SUM_W-1:0]  rd_sum;
    logic [SUM_W-1:0]  head_sum;
    logic [FILL_W-1:0] fill_grow;

    always_comb
    begin
        next_ptr   = wptr_reg + PTR_W'(BURST_BYTES);
        over       = next_ptr > ring_end_reg;
        wrap       = next_ptr >= ring_end_reg;
        move       = hold_reg && (!out_valid_reg || burst.ready);
        issue      = (state_reg == ST_EMIT) && (!hold_reg || move);
        last_word  = wcnt_reg == WCNT_W'(WPB - 1);
        small_rest = {1'b0, fill_reg} < (FILL_W + 1)'(2 * BURST_BYTES);

        rd_sum = SUM_W'(head_reg) + SUM_W'(wcnt_reg);
        if (rd_sum >= SUM_W'(WORDS))
        begin
            rd_sum = rd_sum - SUM_W'(WORDS);
        end
        head_sum = SUM_W'(head_reg) + SUM_W'(WPB);
        if (head_sum >= SUM_W'(WORDS))
        begin
            head_sum = head_sum - SUM_W'(WORDS);
        end
        fill_grow = stat.grow_en ? fill_reg + FILL_W'(stat.grow) : fill_reg;

        state_next      = state_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        wptr_next       = wptr_reg;
        wcnt_next       = wcnt_reg;
        ring_base_next  = ring_base_reg;
        ring_end_next   = ring_end_reg;
        pend_addr_next  = pend_addr_reg;
        pend_blast_next = pend_blast_reg;
        pend_rlast_next = pend_rlast_reg;
        pend_over_next  = pend_over_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fill_next = fill_grow;
                    if (stat.flush_req && (fill_grow >= FILL_W'(BURST_BYTES)))
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    pend_addr_next  = wptr_reg + (PTR_W'(wcnt_reg) << 3);
                    pend_blast_next = last_word;
                    pend_rlast_next = last_word && small_rest;
                    pend_over_next  = over;
                    if (last_word)
                    begin
                        fill_next = fill_reg - FILL_W'(BURST_BYTES);
                        head_next = head_sum[ADDR_W-1:0];
                        wptr_next = wrap ? ring_base_reg : next_ptr;
                        wcnt_next = '0;
                        if (small_rest)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        wcnt_next = wcnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register writes are to come in only while idle; the block itself does not enforce this
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_RING_BASE: ring_base_next = cfg.data;
                CFG_RING_END:  ring_end_next  = cfg.data;
                CFG_START_PTR: wptr_next      = cfg.data;
                default:       ;
            endcase
        end

        if (issue)
        begin
            hold_next = 1'b1;
        end
        else if (move)
        begin
            hold_next = 1'b0;
        end
        else
        begin
            hold_next = hold_reg;
        end

        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_data_next  = out_data_reg;
        out_blast_next = out_blast_reg;
        out_rlast_next = out_rlast_reg;
        out_over_next  = out_over_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = pend_addr_reg;
            out_data_next  = rd_data;
            out_blast_next = pend_blast_reg;
            out_rlast_next = pend_rlast_reg;
            out_over_next  = pend_over_reg;
        end
        else if (burst.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            head_reg      <= '0;
            wptr_reg      <= '0;
            wcnt_reg      <= '0;
            ring_base_reg <= '0;
            ring_end_reg  <= '0;
            hold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            wptr_reg      <= wptr_next;
            wcnt_reg      <= wcnt_next;
            ring_base_reg <= ring_base_next;
            ring_end_reg  <= ring_end_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg  <= pend_addr_next;
        pend_blast_reg <= pend_blast_next;
        pend_rlast_reg <= pend_rlast_next;
        pend_over_reg  <= pend_over_next;
        out_addr_reg   <= out_addr_next;
        out_data_reg   <= out_data_next;
        out_blast_reg  <= out_blast_next;
        out_rlast_reg  <= out_rlast_next;
        out_over_reg   <= out_over_next;
    end

    assign in_ready         = state_reg == ST_IDLE;
    assign fill             = fill_reg;
    assign head             = head_reg;
    assign rd_en            = issue;
    assign rd_addr          = rd_sum[ADDR_W-1:0];
    assign cfg.ready        = 1'b1;
    assign burst.valid      = out_valid_reg;
    assign burst.mem_addr   = out_addr_reg;
    assign burst.mem_data   = out_data_reg;
    assign burst.burst_last = out_blast_reg;
    assign burst.run_last   = out_rlast_reg;
    assign burst.overrun    = out_over_reg;

    `WGB_ASSERT_IMPL(a_no_read_over_stall, clk, rst_n,
        hold_reg && out_valid_reg && !burst.ready, !rd_en,
        "ram read issued while the held word cannot move")
    `WGB_ASSERT_IMPL(a_emit_has_burst, clk, rst_n,
        state_reg == ST_EMIT, fill_reg >= FILL_W'(BURST_BYTES),
        "emitting without a full burst in the buffer")
    `WGB_ASSERT_NEXT(a_run_end_idle, clk, rst_n,
        issue && last_word && small_rest, state_reg == ST_IDLE,
        "sequencer kept running after the final word")
    `WGB_ASSERT_IMPL(a_run_last_on_burst_end, clk, rst_n,
        out_valid_reg && out_rlast_reg, out_blast_reg,
        "run end flagged inside a burst")

endmodule

`default_nettype wire

// ===== hw/rtl/write_gather_burst_pipe_unit.sv =====
// a store is taken while idle; stores that release nothing go back to back, one per cycle
// a releasing store sends the sequencer to its emit state, which reads each burst word
// into the ram read register and then moves it to the output register, one gather ram
// read per cycle while the output is not stalled; the store side waits until the run ends
// reset clears pointer, fill and config; buffer contents stay undefined, no clear pass
`default_nettype none

module write_gather_burst_pipe_unit
    import wgb_pkg::*;
#(
    parameter int BURST_BYTES  = 32,
    parameter int BUFFER_BYTES = 512
)(
    input  logic        clk,
    input  logic        rst_n,
    wgb_store_if.sink   store,
    wgb_burst_if.source burst,
    wgb_cfg_if.sink     cfg
);

    localparam int WORDS  = BUFFER_BYTES / 8;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);

    logic              accept;
    logic              in_ready;
    pack_stat_t        stat;
    logic [FILL_W-1:0] fill;
    logic [ADDR_W-1:0] head;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;

    assign accept      = store.valid && in_ready;
    assign store.ready = in_ready;

    wgb_pack #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_pack (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .op      (store.op),
        .value   (store.value),
        .check   (store.check),
        .fill    (fill),
        .head    (head),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .stat    (stat)
    );

    // full 64-bit words of the gather ring
    wgb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wgb_ctrl #(
        .BURST_BYTES  (BURST_BYTES),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .stat     (stat),
        .in_ready (in_ready),
        .fill     (fill),
        .head     (head),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .burst    (burst),
        .cfg      (cfg)
    );

endmodule

`default_nettype wire
